[hw/rtl/aescfb_pkg.sv]
// Package with the AES-128 CFB word types, constants and round functions.
package aescfb_pkg;

    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned ROUNDS = 10;

    localparam logic [1:0] CFG_KEY_HIGH  = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW   = 2'd1;
    localparam logic [1:0] CFG_DIRECTION = 2'd2;

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    typedef struct packed {
        logic        first_block;
        logic [63:0] iv_high;
        logic [63:0] iv_low;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  block_bytes;
    } t_in_word;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [4:0]  result_bytes;
    } t_out_word;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte 0 sits in bits 127:120.
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int unsigned r = 0; r < 4; r++) begin
            for (int unsigned c = 0; c < 4; c++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, d0, d1, d2, d3;
        t = '0;
        for (int unsigned c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4 * c);
            a1 = get_byte(s, 4 * c + 1);
            a2 = get_byte(s, 4 * c + 2);
            a3 = get_byte(s, 4 * c + 3);
            d0 = xtime(a0);
            d1 = xtime(a1);
            d2 = xtime(a2);
            d3 = xtime(a3);
            t[127 - 32 * c -: 32] = {d0 ^ d1 ^ a1 ^ a2 ^ a3, a0 ^ d1 ^ d2 ^ a2 ^ a3,
                                     a0 ^ a1 ^ d2 ^ d3 ^ a3, d0 ^ a0 ^ a1 ^ a2 ^ d3};
        end
        return t;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rc);
        logic [31:0] t, w0, w1, w2, w3;
        t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

[hw/rtl/aes128_cfb_cipher_top.sv]
// Top level of the AES-128 CFB-128 cipher with its feedback register.
//
// Usage: the configuration channel writes the key halves and the direction
// (1 encrypts, 0 decrypts) while no word is in flight. Each input word holds
// one block of up to 16 bytes, its byte count and an IV that is used in place
// of the feedback register when first_block is set. The whole AES-128 key
// schedule and all ten rounds are unrolled between the feedback register and
// the result register, so one word is accepted per cycle unless the receiver
// stalls, and its result word appears on the output channel in the cycle
// after acceptance. The result register acts as the output stage: input is
// taken whenever the result register is empty or its word is being taken in
// the same cycle, so a receiver stall holds the result and back-pressures the
// input by one word. Reset clears the feedback register and the key to zero,
// sets encrypt mode and empties the result register. Throughput, one word
// per cycle without stalls, is set by the ten-round path of the feedback loop.
module aes128_cfb_cipher_top
    import aescfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [127:0] r_key;
    logic         r_direction;
    logic [127:0] r_feedback;
    logic         r_out_valid;
    t_out_word    r_out;

    logic [127:0] round_key [ROUNDS + 1];
    logic [127:0] state     [ROUNDS + 1];
    logic [127:0] fb_cur, data, keystream, result, n_feedback;
    logic [4:0]   count;
    logic         accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Counts above sixteen saturate, so bit 4 alone marks a full block.
    assign count  = i_in.block_bytes[4] ? 5'd16 : i_in.block_bytes;
    assign fb_cur = i_in.first_block ? {i_in.iv_high, i_in.iv_low} : r_feedback;
    assign data   = {i_in.data_high, i_in.data_low};

    // Unrolled key schedule and rounds; the last round skips MixColumns.
    assign round_key[0] = r_key;
    assign state[0]     = fb_cur ^ r_key;
    for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
        assign round_key[g] = next_round_key(round_key[g - 1], RCON[g - 1]);
        if (g == ROUNDS) begin : g_last
            assign state[g] = sub_shift(state[g - 1]) ^ round_key[g];
        end else begin : g_mid
            assign state[g] = mix_columns(sub_shift(state[g - 1])) ^ round_key[g];
        end
    end
    assign keystream = state[ROUNDS];

    // Bytes at or past the count are forced to zero.
    always_comb begin
        for (int unsigned j = 0; j < BLOCK_BYTES; j++) begin
            result[127 - 8 * j -: 8] = (5'(j) < count) ?
                (data[127 - 8 * j -: 8] ^ keystream[127 - 8 * j -: 8]) : 8'h00;
        end
    end

    // Only a full block advances the chain; a partial one keeps fb_cur.
    assign n_feedback = (count == 5'd16) ? (r_direction ? result : data) : fb_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_direction <= 1'b1;
            r_feedback  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_KEY_HIGH:  r_key[127:64] <= i_cfg_data;
                    CFG_KEY_LOW:   r_key[63:0]   <= i_cfg_data;
                    CFG_DIRECTION: r_direction   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_feedback  <= n_feedback;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.result_high  <= result[127:64];
            r_out.result_low   <= result[63:0];
            r_out.result_bytes <= count;
        end
    end

endmodule
